// ===== hw/rtl/mqrf_pkg.sv =====
// Shared types, sizes and codes for the multi-queue ring FIFO.
package mqrf_pkg;

    // Sizing of the queue bank
    localparam int QUEUE_SLOTS = 8;
    localparam int SLOT_DEPTH  = 16;
    localparam int ITEM_BITS   = 32;

    // Derived widths
    localparam int SLOT_W    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int PTR_W     = $clog2(SLOT_DEPTH);
    localparam int CAP_W     = $clog2(SLOT_DEPTH + 1);
    localparam int STORE_W   = (ITEM_BITS < 32) ? ITEM_BITS : 32;
    localparam int MEM_DEPTH = QUEUE_SLOTS * SLOT_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Stream packing
    localparam int ID_W        = 32;
    localparam int DATA_W      = 32;
    localparam int LEN_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int TUSER_W     = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;
    localparam int IN_PAD_W    = IN_TDATA_W - ID_W - LEN_W - DATA_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - ID_W - DATA_W;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        KIND_CREATE  = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_SEND    = 2'd2,
        KIND_RECEIVE = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERR   = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/mqrf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mqrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mqrf_ctrl.sv =====
// Sequencing state machine: accept, execute, respond.
module mqrf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output mqrf_pkg::cmd_t cmd,
    input  mqrf_pkg::stat_t stat
);
    import mqrf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    s_tready     = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted transaction is always executed next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_EXEC))
        else $error("accepted transaction not executed");

    // Results are only pushed into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded into occupied output register");

endmodule

// ===== hw/rtl/mqrf_dp.sv =====
// Queue tables, identifier counter, item memory and output register.
module mqrf_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mqrf_pkg::cmd_t                     cmd,
    output mqrf_pkg::stat_t                    stat,
    input  logic [mqrf_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [mqrf_pkg::TUSER_W-1:0]       s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mqrf_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import mqrf_pkg::*;

    // Captured transaction
    kind_t              kind_reg;
    logic [ID_W-1:0]    qid_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [DATA_W-1:0]  data_reg;

    // Per-slot tables
    logic [ID_W-1:0]    ident_reg [QUEUE_SLOTS];
    logic [CAP_W-1:0]   cap_reg   [QUEUE_SLOTS];
    logic [PTR_W-1:0]   rp_reg    [QUEUE_SLOTS];
    logic [PTR_W-1:0]   wp_reg    [QUEUE_SLOTS];
    logic [CAP_W-1:0]   fc_reg    [QUEUE_SLOTS];
    logic [ID_W-1:0]    ctr_reg;
    logic [ID_W-1:0]    ctr_next;

    // Pending result
    status_t            res_status_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic               res_rd_reg;

    // Output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // Lookup and decode
    logic [SLOT_W-1:0]  hit_idx;
    logic [SLOT_W-1:0]  free_idx;
    logic               any_hit;
    logic               any_free;
    logic               len_ok;
    logic               create_ok;
    logic               send_ok;
    logic               recv_ok;
    logic [CAP_W-1:0]   hit_cap;
    logic [CAP_W-1:0]   hit_fc;
    logic [PTR_W-1:0]   hit_rp;
    logic [PTR_W-1:0]   hit_wp;
    status_t            status_calc;

    // Item memory ports
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [STORE_W-1:0] mem_rdata;
    logic [DATA_W-1:0]  read_data;

    // Table invariant flag
    logic               tables_ok;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                   input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = CAP_W'(p) + CAP_W'(1);
        return (n >= cap) ? '0 : PTR_W'(n);
    endfunction

    // Capture an accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(s_tuser);
            qid_reg  <= s_tdata[ID_W-1:0];
            len_reg  <= s_tdata[ID_W+LEN_W-1:ID_W];
            data_reg <= s_tdata[ID_W+LEN_W+DATA_W-1:ID_W+LEN_W];
        end
    end

    // Find lowest matching slot and lowest free slot
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        any_hit  = 1'b0;
        any_free = 1'b0;
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--)
        begin
            if (qid_reg != '0 && ident_reg[i] == qid_reg)
            begin
                hit_idx = SLOT_W'(i);
                any_hit = 1'b1;
            end
            if (ident_reg[i] == '0)
            begin
                free_idx = SLOT_W'(i);
                any_free = 1'b1;
            end
        end
    end

    // Decode the operation outcome
    always_comb
    begin
        hit_cap   = cap_reg[hit_idx];
        hit_fc    = fc_reg[hit_idx];
        hit_rp    = rp_reg[hit_idx];
        hit_wp    = wp_reg[hit_idx];
        len_ok    = (len_reg != '0) && (32'(len_reg) <= 32'(SLOT_DEPTH));
        create_ok = (kind_reg == KIND_CREATE) && len_ok && any_free;
        send_ok   = (kind_reg == KIND_SEND) && any_hit && (hit_fc < hit_cap);
        recv_ok   = (kind_reg == KIND_RECEIVE) && any_hit && (hit_fc != '0);
        ctr_next  = (ctr_reg == '1) ? ID_W'(1) : ctr_reg + ID_W'(1);
        status_calc = ST_ERR;
        case (kind_reg)
            KIND_CREATE:  status_calc = create_ok ? ST_OK : ST_ERR;
            KIND_DELETE:  status_calc = any_hit ? ST_OK : ST_ERR;
            KIND_SEND:    status_calc = send_ok ? ST_OK : ST_ERR;
            KIND_RECEIVE:
            begin
                if (!any_hit)
                begin
                    status_calc = ST_ERR;
                end
                else if (hit_fc == '0)
                begin
                    status_calc = ST_EMPTY;
                end
                else
                begin
                    status_calc = ST_OK;
                end
            end
            default:      status_calc = ST_ERR;
        endcase
    end

    // Update slot tables and identifier counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                ident_reg[i] <= '0;
                cap_reg[i]   <= '0;
                rp_reg[i]    <= '0;
                wp_reg[i]    <= '0;
                fc_reg[i]    <= '0;
            end
            ctr_reg <= ID_W'(1);
        end
        else if (cmd.exec)
        begin
            case (kind_reg)
                KIND_CREATE:
                begin
                    if (create_ok)
                    begin
                        ident_reg[free_idx] <= ctr_reg;
                        cap_reg[free_idx]   <= CAP_W'(len_reg);
                        rp_reg[free_idx]    <= '0;
                        wp_reg[free_idx]    <= '0;
                        fc_reg[free_idx]    <= '0;
                        ctr_reg             <= ctr_next;
                    end
                end
                KIND_DELETE:
                begin
                    if (any_hit)
                    begin
                        ident_reg[hit_idx] <= '0;
                        cap_reg[hit_idx]   <= '0;
                        rp_reg[hit_idx]    <= '0;
                        wp_reg[hit_idx]    <= '0;
                        fc_reg[hit_idx]    <= '0;
                    end
                end
                KIND_SEND:
                begin
                    if (send_ok)
                    begin
                        wp_reg[hit_idx] <= ring_next(hit_wp, hit_cap);
                        fc_reg[hit_idx] <= hit_fc + CAP_W'(1);
                    end
                end
                KIND_RECEIVE:
                begin
                    if (recv_ok)
                    begin
                        rp_reg[hit_idx] <= ring_next(hit_rp, hit_cap);
                        fc_reg[hit_idx] <= hit_fc - CAP_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold the result until the memory read returns
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= status_calc;
            res_id_reg     <= create_ok ? ctr_reg : '0;
            res_rd_reg     <= recv_ok;
        end
    end

    // Item memory access: slot region base plus ring pointer
    assign mem_we    = cmd.exec && send_ok;
    assign mem_re    = cmd.exec && recv_ok;
    assign mem_waddr = ADDR_W'(ADDR_W'(hit_idx) * ADDR_W'(SLOT_DEPTH) + ADDR_W'(hit_wp));
    assign mem_raddr = ADDR_W'(ADDR_W'(hit_idx) * ADDR_W'(SLOT_DEPTH) + ADDR_W'(hit_rp));

    mqrf_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MEM_DEPTH)
    ) u_item_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_reg[STORE_W-1:0]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign read_data = res_rd_reg ? DATA_W'(mem_rdata) : '0;

    // Output register: load on command, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, read_data, res_id_reg, res_status_reg};
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Every slot keeps fill within capacity; a free slot is empty
    always_comb
    begin
        tables_ok = 1'b1;
        for (int i = 0; i < QUEUE_SLOTS; i++)
        begin
            if (fc_reg[i] > cap_reg[i])
            begin
                tables_ok = 1'b0;
            end
            if (ident_reg[i] == '0 && fc_reg[i] != '0)
            begin
                tables_ok = 1'b0;
            end
        end
    end

    a_tables: assert property (@(posedge clk) disable iff (!rst_n)
        tables_ok)
        else $error("slot fill count inconsistent with slot state");

    a_ctr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctr_reg != '0)
        else $error("identifier counter reached zero");

    a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("item memory written and read by one transaction");

endmodule

// ===== hw/rtl/multi_queue_ring_fifo_top.sv =====
// Top level of the multi-queue ring FIFO: stream ports, controller and datapath.
//
// A bank of eight ring-buffer queues, each with a sixteen-item region of a shared
// item memory. Every input transaction (create, delete, send, receive) answers with
// exactly one result transaction. After acceptance an operation passes through EXEC,
// which looks up the slot by identifier, updates its tables and issues the item
// memory's registered read, then RESP, which loads the result into the output register
// once it is free while the next transaction is accepted; no new transaction is taken
// before the previous result is loaded. RESP is set by the registered read port of the
// item memory. A stalled sink leaves at most two finished results inside the block:
// one in the output register and one waiting to be loaded into it, and input is held
// off meanwhile. The item memory needs no clearing after reset.
module multi_queue_ring_fifo_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] queue_id, [36:32] length, [68:37] item_data, [71:69] zero
    input  logic [mqrf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] kind
    input  logic [mqrf_pkg::TUSER_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [33:2] new_id, [65:34] read_data, [71:66] zero
    output logic [mqrf_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import mqrf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    mqrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Tables, item memory and result register
    mqrf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the multi-queue ring FIFO: random streams against a predictor.
module tb;
    import mqrf_pkg::*;

    localparam int RANDOM_OPS   = 550;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_OPS   = 100;
    localparam int TAIL_CYCLES  = 8;
    localparam int RUN_LIMIT    = 3000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [TUSER_W-1:0]     s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Handshake between the stimulus and the sink process
    bit sink_hold_req = 1'b0;
    bit settle_phase = 1'b0;

    // One expected result transaction
    typedef struct {
        status_t     status;
        logic [31:0] new_id;
        logic [31:0] read_data;
    } queue_reply_t;

    // Queue bank shadow: predicts each reply and checks the returned ones in order
    class queue_bank_scoreboard;
        logic [31:0]      ident [QUEUE_SLOTS];
        logic [CAP_W-1:0] capacity [QUEUE_SLOTS];
        logic [PTR_W-1:0] rd_ptr [QUEUE_SLOTS];
        logic [PTR_W-1:0] wr_ptr [QUEUE_SLOTS];
        logic [CAP_W-1:0] fill [QUEUE_SLOTS];
        logic [31:0]      item_mem [MEM_DEPTH];
        logic [31:0]      next_id;
        queue_reply_t     pending_replies [$];
        int               errors;
        int               kind_seen [4];
        int               status_seen [3];

        function new();
            foreach (ident[i])
                clear_slot(i);
            foreach (item_mem[i])
                item_mem[i] = '0;
            next_id = 32'd1;
            errors = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void clear_slot(int s);
            ident[s] = '0;
            capacity[s] = '0;
            rd_ptr[s] = '0;
            wr_ptr[s] = '0;
            fill[s] = '0;
        endfunction

        // Lowest slot holding the identifier; zero never matches
        function int find_slot(logic [31:0] id);
            if (id == 32'd0)
                return -1;
            for (int i = 0; i < QUEUE_SLOTS; i++)
                if (ident[i] == id)
                    return i;
            return -1;
        endfunction

        function logic [PTR_W-1:0] ring_advance(logic [PTR_W-1:0] p, logic [CAP_W-1:0] c);
            return (int'(p) + 1 >= int'(c)) ? '0 : PTR_W'(int'(p) + 1);
        endfunction

        // Apply an accepted request to the shadow and queue its reply
        function void note_request(kind_t kind, logic [31:0] qid, logic [LEN_W-1:0] len,
                                   logic [31:0] data);
            queue_reply_t r;
            int s;
            r.status = ST_ERR;
            r.new_id = '0;
            r.read_data = '0;
            s = -1;
            kind_seen[int'(kind)]++;
            if (kind == KIND_CREATE)
            begin
                if (len != 0 && int'(len) <= SLOT_DEPTH)
                    for (int i = QUEUE_SLOTS - 1; i >= 0; i--)
                        if (ident[i] == 32'd0)
                            s = i;
                if (s >= 0)
                begin
                    r.new_id = next_id;
                    next_id = next_id + 32'd1;
                    if (next_id == 32'd0)
                        next_id = 32'd1;
                    clear_slot(s);
                    ident[s] = r.new_id;
                    capacity[s] = CAP_W'(len);
                    r.status = ST_OK;
                end
            end
            else
            begin
                s = find_slot(qid);
                if (s >= 0)
                begin
                    case (kind)
                        KIND_DELETE:
                        begin
                            clear_slot(s);
                            r.status = ST_OK;
                        end
                        KIND_SEND:
                        begin
                            if (fill[s] < capacity[s])
                            begin
                                item_mem[s * SLOT_DEPTH + int'(wr_ptr[s])] = data;
                                wr_ptr[s] = ring_advance(wr_ptr[s], capacity[s]);
                                fill[s] = fill[s] + 1'b1;
                                r.status = ST_OK;
                            end
                        end
                        default:
                        begin
                            if (fill[s] == 0)
                            begin
                                r.status = ST_EMPTY;
                            end
                            else
                            begin
                                r.read_data = item_mem[s * SLOT_DEPTH + int'(rd_ptr[s])];
                                rd_ptr[s] = ring_advance(rd_ptr[s], capacity[s]);
                                fill[s] = fill[s] - 1'b1;
                                r.status = ST_OK;
                            end
                        end
                    endcase
                end
            end
            status_seen[int'(r.status)]++;
            pending_replies.push_back(r);
        endfunction

        // Compare a returned result with the oldest expected reply
        function void check_reply(logic [OUT_TDATA_W-1:0] tdata);
            queue_reply_t r;
            logic [STATUS_W-1:0] got_status;
            logic [31:0] got_id;
            logic [31:0] got_data;
            got_status = tdata[STATUS_W-1:0];
            got_id = tdata[STATUS_W +: ID_W];
            got_data = tdata[STATUS_W + ID_W +: DATA_W];
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result: status %0d new_id 0x%08h read_data 0x%08h",
                       got_status, got_id, got_data);
                errors++;
                return;
            end
            r = pending_replies.pop_front();
            if (got_status !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, got_status);
                errors++;
            end
            if (got_id !== r.new_id)
            begin
                $error("new_id: expected 0x%08h, actual 0x%08h", r.new_id, got_id);
                errors++;
            end
            if (got_data !== r.read_data)
            begin
                $error("read_data: expected 0x%08h, actual 0x%08h", r.read_data, got_data);
                errors++;
            end
        endfunction
    endclass

    queue_bank_scoreboard sb;

    multi_queue_ring_fifo_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Offer one request, hold it until accepted, then maybe idle for a burst
    task automatic issue_op(kind_t kind, logic [31:0] qid, logic [LEN_W-1:0] len,
                            logic [31:0] data);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{IN_PAD_W{1'b0}}, data, len, qid};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(kind, qid, len, data);
        if (!settle_phase && !sink_hold_req && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_replies.size() != 0);
    endtask

    // Mostly a live identifier, sometimes zero or an arbitrary value
    function automatic logic [31:0] pick_target();
        logic [31:0] live [$];
        foreach (sb.ident[i])
            if (sb.ident[i] != 32'd0)
                live.push_back(sb.ident[i]);
        if (live.size() == 0 || $urandom_range(0, 99) < 8)
            return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom());
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // One random request, weighted toward traffic on live queues
    task automatic random_op();
        int pick;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            if ($urandom_range(0, 9) == 0)
                len = LEN_W'($urandom_range(0, 31));
            else if ($urandom_range(0, 1) == 0)
                len = LEN_W'($urandom_range(1, 4));
            else
                len = LEN_W'($urandom_range(1, SLOT_DEPTH));
            issue_op(KIND_CREATE, 32'($urandom()), len, 32'($urandom()));
        end
        else if (pick < 20)
        begin
            issue_op(KIND_DELETE, pick_target(), LEN_W'($urandom_range(0, 31)),
                     32'($urandom()));
        end
        else if (pick < 58)
        begin
            issue_op(KIND_SEND, pick_target(), LEN_W'($urandom_range(0, 31)),
                     32'($urandom()));
        end
        else if (pick < 94)
        begin
            issue_op(KIND_RECEIVE, pick_target(), LEN_W'($urandom_range(0, 31)),
                     32'($urandom()));
        end
        else
        begin
            issue_op(kind_t'($urandom_range(0, 3)), 32'($urandom()),
                     LEN_W'($urandom_range(0, 31)), 32'($urandom()));
        end
    endtask

    // Sink side: random stall bursts, one long hold on request, none while settling
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                sink_hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!settle_phase && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check every result transaction
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata);

    // Main sequence
    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identifier zero never matches
        issue_op(KIND_RECEIVE, 32'd0, 5'd0, 32'd0);
        issue_op(KIND_SEND, 32'd0, 5'd0, 32'hFFFF_FFFF);
        issue_op(KIND_DELETE, 32'd0, 5'd0, 32'd0);
        // Bad create lengths
        issue_op(KIND_CREATE, 32'd0, 5'd0, 32'd0);
        issue_op(KIND_CREATE, 32'd0, 5'd17, 32'd0);
        issue_op(KIND_CREATE, 32'hFFFF_FFFF, 5'd31, 32'd0);
        // Smallest and largest queues; identifiers start at one after reset
        issue_op(KIND_CREATE, 32'd0, 5'd1, 32'd0);
        issue_op(KIND_CREATE, 32'd0, 5'd16, 32'd0);
        // Full and empty on the one-item queue
        issue_op(KIND_SEND, 32'd1, 5'd0, 32'hFFFF_FFFF);
        issue_op(KIND_SEND, 32'd1, 5'd0, 32'h0000_0000);
        issue_op(KIND_RECEIVE, 32'd1, 5'd0, 32'd0);
        issue_op(KIND_RECEIVE, 32'd1, 5'd0, 32'd0);
        issue_op(KIND_SEND, 32'd2, 5'd0, 32'h5A5A_5A5A);
        issue_op(KIND_RECEIVE, 32'd2, 5'd31, 32'hFFFF_FFFF);
        // Unknown and deleted identifiers
        issue_op(KIND_SEND, 32'hFFFF_FFFF, 5'd31, 32'hA5A5_A5A5);
        issue_op(KIND_DELETE, 32'd1, 5'd0, 32'd0);
        issue_op(KIND_DELETE, 32'd1, 5'd0, 32'd0);
        // Fill every slot, then one create too many
        repeat (QUEUE_SLOTS - 1)
            issue_op(KIND_CREATE, 32'd0, 5'd2, 32'd0);
        issue_op(KIND_CREATE, 32'd0, 5'd16, 32'd0);
        drain_results();

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == 150)
                sink_hold_req = 1'b1;
            if (n == 300)
                drain_results();
            if (n == RANDOM_OPS - SETTLE_OPS)
                settle_phase = 1'b1;
            random_op();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests: create %0d, delete %0d, send %0d, receive %0d.",
                 sb.kind_seen[0] + sb.kind_seen[1] + sb.kind_seen[2] + sb.kind_seen[3],
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
        $display("Replies seen: %0d ok, %0d error, %0d empty, with stalls on both sides.",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        if (sb.errors == 0)
            $display("** multi_queue_ring_fifo_top: PASSED **");
        else
            $display("** multi_queue_ring_fifo_top: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout: %0d results still expected", sb.pending_replies.size());
        $display("** multi_queue_ring_fifo_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mqrf_pkg.sv
hw/rtl/mqrf_ram.sv
hw/rtl/mqrf_ctrl.sv
hw/rtl/mqrf_dp.sv
hw/rtl/multi_queue_ring_fifo_top.sv
test/tb.sv
